// File: rtl/core/sv32_page_walker_defines.svh
// Assertion helpers for the page walker checker.
`ifndef SV32_PAGE_WALKER_DEFINES_SVH
`define SV32_PAGE_WALKER_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define SV32PW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SV32PW_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/sv32pw_pkg.sv
`default_nettype none

package sv32pw_pkg;

	localparam int unsigned VA_W   = 32;
	localparam int unsigned PA_W   = 34;
	localparam int unsigned PPN_W  = 22;
	localparam int unsigned VPN_W  = 10;
	localparam int unsigned OFFS_W = 12;

	// request op codes
	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_MEM_WORD  = 1'b1;

	// access kinds
	localparam logic [1:0] ACC_FETCH   = 2'd0;
	localparam logic [1:0] ACC_LOAD    = 2'd1;
	localparam logic [1:0] ACC_STORE   = 2'd2;
	localparam logic [1:0] ACC_ILLEGAL = 2'd3;

	// response kinds
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// fault codes
	localparam logic [2:0] FLT_NONE    = 3'd0;
	localparam logic [2:0] FLT_L1_INV  = 3'd1;
	localparam logic [2:0] FLT_L2_INV  = 3'd2;
	localparam logic [2:0] FLT_PERM    = 3'd3;
	localparam logic [2:0] FLT_ILLEGAL = 3'd4;

	// PTE bit positions
	localparam int unsigned PTE_V = 0;
	localparam int unsigned PTE_R = 1;
	localparam int unsigned PTE_W = 2;
	localparam int unsigned PTE_X = 3;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_L1   = 3'b010,
		PH_L2   = 3'b100
	} phase_t;

	typedef struct packed {
		logic              op;
		logic [VA_W-1:0]   vaddr;
		logic [1:0]        access;
		logic [31:0]       mem_word;
	} req_t;

	typedef struct packed {
		logic              kind;
		logic [PA_W-1:0]   address;
		logic [2:0]        fault;
	} rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/sv32_page_walker.sv
// Channel | Dir | Handshake          | Word
// req     | in  | req_valid/req_stall | req_t: op, vaddr, access, mem_word
// rsp     | out | rsp_valid/rsp_stall | rsp_t: kind, address, fault
// cfg     | in  | cfg_valid/cfg_ready | root_table_ppn (22 bits)
//
// Each req word gives exactly one rsp word: it is held in the input register,
// then in the output register. One word per cycle sustained while rsp is not
// stalled: the input register feeds a single pass of field extraction and a
// permission check into the output register.
// Walk state updates as a word leaves the input register, so the next word
// always sees it. arst_n clears both valid bits, the walk state and root PPN.
// A stalled rsp holds; req_stall rises only when the input register is full
// and cannot drain into the output register.
`default_nettype none

module sv32_page_walker
	import sv32pw_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire req_t             req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_t                  rsp,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [PPN_W-1:0] cfg_data
);

	// input stage
	logic req_valid_s1;
	req_t req_s1;

	// output stage
	logic rsp_valid_s2;
	rsp_t rsp_s2;

	// walk state
	phase_t            phase_q;
	logic [VA_W-1:0]   saved_vaddr_q;
	logic [1:0]        saved_access_q;
	logic [PPN_W-1:0]  root_ppn_q;

	logic   s2_free;
	logic   s1_fire;
	logic   req_take;
	rsp_t   rsp_d;
	phase_t phase_d;
	logic   perm_ok;
	logic   perm_legal;

	assign s2_free   = !rsp_valid_s2 || !rsp_stall;
	assign s1_fire   = req_valid_s1 && s2_free;
	assign req_stall = req_valid_s1 && !s2_free;
	assign req_take  = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	// permission bit needed by the saved access kind
	always_comb begin
		perm_ok    = 1'b0;
		perm_legal = 1'b1;
		case (saved_access_q)
			ACC_FETCH: perm_ok = req_s1.mem_word[PTE_X];
			ACC_LOAD:  perm_ok = req_s1.mem_word[PTE_R];
			ACC_STORE: perm_ok = req_s1.mem_word[PTE_W];
			default:   perm_legal = 1'b0;
		endcase
	end

	// one pass: next response word and next walk phase
	always_comb begin
		rsp_d.kind    = KIND_DONE;
		rsp_d.address = '0;
		rsp_d.fault   = FLT_NONE;
		phase_d       = phase_q;
		if (req_s1.op == OP_TRANSLATE) begin
			// root PTE address: root PPN page plus VPN[1] * 4
			rsp_d.kind    = KIND_READ;
			rsp_d.address = {root_ppn_q, req_s1.vaddr[VA_W-1 -: VPN_W], 2'b00};
			phase_d       = PH_L1;
		end else begin
			case (phase_q)
				PH_L1: begin
					if (!req_s1.mem_word[PTE_V]) begin
						rsp_d.fault = FLT_L1_INV;
						phase_d     = PH_IDLE;
					end else begin
						rsp_d.kind    = KIND_READ;
						rsp_d.address = {req_s1.mem_word[31:10],
							saved_vaddr_q[OFFS_W +: VPN_W], 2'b00};
						phase_d       = PH_L2;
					end
				end
				PH_L2: begin
					phase_d = PH_IDLE;
					if (!req_s1.mem_word[PTE_V]) begin
						rsp_d.fault = FLT_L2_INV;
					end else if (!perm_legal) begin
						rsp_d.fault = FLT_ILLEGAL;
					end else if (!perm_ok) begin
						rsp_d.fault = FLT_PERM;
					end else begin
						rsp_d.address = {req_s1.mem_word[31:10],
							saved_vaddr_q[OFFS_W-1:0]};
					end
				end
				default: begin
					// memory word with no read outstanding; state kept
					rsp_d.fault = FLT_ILLEGAL;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1   <= 1'b0;
			rsp_valid_s2   <= 1'b0;
			phase_q        <= PH_IDLE;
			saved_vaddr_q  <= '0;
			saved_access_q <= '0;
			root_ppn_q     <= '0;
		end else begin
			if (!req_stall) begin
				req_valid_s1 <= req_valid;
			end
			if (s2_free) begin
				rsp_valid_s2 <= req_valid_s1;
			end
			if (s1_fire) begin
				phase_q <= phase_d;
				if (req_s1.op == OP_TRANSLATE) begin
					saved_vaddr_q  <= req_s1.vaddr;
					saved_access_q <= req_s1.access;
				end
			end
			if (cfg_valid && cfg_ready) begin
				root_ppn_q <= cfg_data;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1 <= req;
		end
		if (s1_fire) begin
			rsp_s2 <= rsp_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/sv32pw_checker.sv
`default_nettype none
`include "sv32_page_walker_defines.svh"

module sv32pw_checker
	import sv32pw_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             rsp_valid,
	input wire logic             rsp_stall,
	input wire rsp_t             rsp
);

	// stalled rsp word holds
	`SV32PW_ASSERT(a_rsp_hold,
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp),
		"rsp changed under stall")

	// faulted translations carry a zero address and are finished
	`SV32PW_ASSERT(a_fault_done,
		rsp_valid && rsp.fault != FLT_NONE |-> rsp.kind == KIND_DONE && rsp.address == '0,
		"fault word malformed")

	// read requests never fault and are word aligned
	`SV32PW_ASSERT(a_read_clean,
		rsp_valid && rsp.kind == KIND_READ |-> rsp.fault == FLT_NONE && rsp.address[1:0] == 2'b00,
		"bad read request")

	// no response word while in reset
	`SV32PW_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !rsp_valid, "rsp valid in reset")

endmodule

bind sv32_page_walker sv32pw_checker u_sv32pw_checker (.*);

`default_nettype wire
